>>> hdl/fme7_pkg.sv
// ----------------------------------------------------------------------------
// fme7_pkg
// Types and constants shared by the FME-7 bank mapper with cycle IRQ.
// ----------------------------------------------------------------------------
package fme7_pkg;

  localparam int CHR_SLOTS = 8;
  localparam int CHR_IDX_W = $clog2(CHR_SLOTS);
  localparam int PRG_SLOTS = 3;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_CPU_XLATE = 2'd2,
    CMD_PPU_XLATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REGION_ROM      = 2'd0,
    REGION_WRAM     = 2'd1,
    REGION_OPEN_BUS = 2'd2,
    REGION_UNMAPPED = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    MIRROR_VERTICAL   = 2'd0,
    MIRROR_HORIZONTAL = 2'd1,
    MIRROR_SINGLE_A   = 2'd2,
    MIRROR_SINGLE_B   = 2'd3
  } mirror_e;

  // internal register indexes
  localparam logic [3:0] REG_WINDOW  = 4'h8;
  localparam logic [3:0] REG_PRG0    = 4'h9;
  localparam logic [3:0] REG_PRG1    = 4'hA;
  localparam logic [3:0] REG_PRG2    = 4'hB;
  localparam logic [3:0] REG_MIRROR  = 4'hC;
  localparam logic [3:0] REG_IRQ_CTL = 4'hD;
  localparam logic [3:0] REG_CNT_LO  = 4'hE;
  localparam logic [3:0] REG_CNT_HI  = 4'hF;

  // address pages (bits 15:13)
  localparam logic [2:0] PAGE_WINDOW = 3'b011;
  localparam logic [2:0] PAGE_SELECT = 3'b100;
  localparam logic [2:0] PAGE_LOAD   = 3'b101;
  localparam logic [2:0] PAGE_FIXED  = 3'b111;
  localparam logic [2:0] PAGE_CHR    = 3'b000;

  localparam logic [5:0] PRG_FIXED_BANK = 6'h3F;

  typedef struct packed {
    logic [7:0]  cycle_count;
    logic [7:0]  write_data;
    logic [15:0] address;
    cmd_e        cmd;
  } item_t;

  typedef struct packed {
    logic       ram_write_enable;
    mirror_e    mirror_mode;
    region_e    region_kind;
    logic [7:0] bank_number;
    logic       irq_out;
  } result_t;

endpackage

>>> hdl/fme7_bank_mapper_irq_top.sv
// ----------------------------------------------------------------------------
// fme7_bank_mapper_irq_top
// FME-7 style bank mapper with 16-bit cycle IRQ counter.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser cmd, tdata addr/data/cycles
//   m_axis    out        tvalid/tready           tuser region, tdata result
//   cfg       in         cfg_we_i                cfg_wdata_i board mirror flag
//
// One transaction per cycle sustained while m_axis_tready_i is high; each passes the input
// register, then state update and result register in one pass.
// Reset gives horizontal mirroring, identity CHR banks, PRG banks 0x3F.
// Output stall backs up through both registers to s_axis_tready_o.
// ----------------------------------------------------------------------------
module fme7_bank_mapper_irq_top
  import fme7_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] cmd
  input  logic [31:0] s_axis_tdata_i,  // [15:0] address, [23:16] write_data,
                                       // [31:24] cycle_count
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [1:0]  m_axis_tuser_o,  // [1:0] region_kind
  output logic [15:0] m_axis_tdata_o   // [0] irq_out, [8:1] bank_number,
                                       // [10:9] mirror_mode, [11] ram_write_enable,
                                       // [15:12] zero
);

  item_t   in_item;
  item_t   core_item;
  logic    core_valid;
  logic    out_ready;
  logic    step;
  result_t core_result;
  result_t out_result;

  assign in_item.cmd         = cmd_e'(s_axis_tuser_i);
  assign in_item.address     = s_axis_tdata_i[15:0];
  assign in_item.write_data  = s_axis_tdata_i[23:16];
  assign in_item.cycle_count = s_axis_tdata_i[31:24];

  assign step = core_valid && out_ready;

  fme7_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (core_valid),
    .take_i  (step),
    .item_o  (core_item)
  );

  fme7_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_flag_i (cfg_wdata_i),
    .step_i     (step),
    .item_i     (core_item),
    .result_o   (core_result)
  );

  fme7_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (core_valid),
    .ready_o  (out_ready),
    .result_i (core_result),
    .valid_o  (m_axis_tvalid_o),
    .take_i   (m_axis_tready_i),
    .result_o (out_result)
  );

  assign m_axis_tuser_o = out_result.region_kind;
  assign m_axis_tdata_o = {4'd0, out_result.ram_write_enable, out_result.mirror_mode,
                           out_result.bank_number, out_result.irq_out};

endmodule

>>> hdl/fme7_in_stage.sv
// ----------------------------------------------------------------------------
// fme7_in_stage
// Input register: holds one accepted transaction until the core takes it.
// ----------------------------------------------------------------------------
module fme7_in_stage
  import fme7_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

>>> hdl/fme7_core.sv
// ----------------------------------------------------------------------------
// fme7_core
// Mapper registers, IRQ counter and address translation for one transaction.
// ----------------------------------------------------------------------------
module fme7_core
  import fme7_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_flag_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [3:0]  sel_q, sel_d;
  logic [7:0]  chr_q [CHR_SLOTS];
  logic [7:0]  chr_d [CHR_SLOTS];
  logic [5:0]  prg_q [PRG_SLOTS];
  logic [5:0]  prg_d [PRG_SLOTS];
  logic [7:0]  window_q, window_d;
  mirror_e     mirror_q, mirror_d;
  logic [7:0]  irq_ctl_q, irq_ctl_d;
  logic [15:0] cnt_q, cnt_d;
  logic        pend_q, pend_d;

  logic [16:0] cnt_sub;
  logic [2:0]  page;
  logic [7:0]  bank;
  region_e     region;

  assign page    = item_i.address[15:13];
  assign cnt_sub = {1'b0, cnt_q} - {9'd0, item_i.cycle_count};

  always_comb begin
    sel_d     = sel_q;
    chr_d     = chr_q;
    prg_d     = prg_q;
    window_d  = window_q;
    mirror_d  = mirror_q;
    irq_ctl_d = irq_ctl_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    bank      = 8'd0;
    region    = REGION_UNMAPPED;

    unique case (item_i.cmd)
      CMD_WRITE: begin
        if (page == PAGE_SELECT) begin
          sel_d = item_i.write_data[3:0];
        end else if (page == PAGE_LOAD) begin
          if (!sel_q[3]) begin
            chr_d[sel_q[CHR_IDX_W-1:0]] = item_i.write_data;
          end else begin
            unique case (sel_q)
              REG_WINDOW:  window_d = item_i.write_data;
              REG_PRG0:    prg_d[0] = item_i.write_data[5:0];
              REG_PRG1:    prg_d[1] = item_i.write_data[5:0];
              REG_PRG2:    prg_d[2] = item_i.write_data[5:0];
              REG_MIRROR:  mirror_d = mirror_e'(item_i.write_data[1:0]);
              REG_IRQ_CTL: begin
                irq_ctl_d = item_i.write_data;
                pend_d    = 1'b0;
              end
              REG_CNT_LO:  cnt_d = {cnt_q[15:8], item_i.write_data};
              REG_CNT_HI:  cnt_d = {item_i.write_data, cnt_q[7:0]};
              default: ;
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (irq_ctl_q[0]) begin
          cnt_d = cnt_sub[15:0];
          // borrow out means the counter wrapped
          if (cnt_sub[16] && irq_ctl_q[7]) begin
            pend_d = 1'b1;
          end
        end
      end
      CMD_CPU_XLATE: begin
        if (page == PAGE_FIXED) begin
          bank   = {2'b00, PRG_FIXED_BANK};
          region = REGION_ROM;
        end else if (item_i.address[15]) begin
          region = REGION_ROM;
          case (item_i.address[14:13])
            2'd0:    bank = {2'b00, prg_q[0]};
            2'd1:    bank = {2'b00, prg_q[1]};
            default: bank = {2'b00, prg_q[2]};
          endcase
        end else if (page == PAGE_WINDOW) begin
          if (!window_q[6]) begin
            bank   = {2'b00, window_q[5:0]};
            region = REGION_ROM;
          end else if (window_q[7]) begin
            region = REGION_WRAM;
          end else begin
            region = REGION_OPEN_BUS;
          end
        end
      end
      CMD_PPU_XLATE: begin
        if (page == PAGE_CHR) begin
          bank   = chr_q[item_i.address[10 +: CHR_IDX_W]];
          region = REGION_ROM;
        end
      end
      default: ;
    endcase

    result_o.irq_out          = pend_d;
    result_o.bank_number      = bank;
    result_o.region_kind      = region;
    result_o.mirror_mode      = mirror_d;
    result_o.ram_write_enable = window_d[7] && window_d[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= 4'd0;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_q[i] <= 8'(i);
      end
      for (int i = 0; i < PRG_SLOTS; i++) begin
        prg_q[i] <= PRG_FIXED_BANK;
      end
      window_q  <= 8'd0;
      mirror_q  <= MIRROR_HORIZONTAL;
      irq_ctl_q <= 8'd0;
      cnt_q     <= 16'd0;
      pend_q    <= 1'b0;
    end else if (cfg_we_i) begin
      // board strap reloads mirroring
      mirror_q <= cfg_flag_i ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
    end else if (step_i) begin
      sel_q     <= sel_d;
      chr_q     <= chr_d;
      prg_q     <= prg_d;
      window_q  <= window_d;
      mirror_q  <= mirror_d;
      irq_ctl_q <= irq_ctl_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
    end
  end

endmodule

>>> hdl/fme7_out_stage.sv
// ----------------------------------------------------------------------------
// fme7_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module fme7_out_stage
  import fme7_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  output logic    ready_o,
  input  result_t result_i,
  output logic    valid_o,
  input  logic    take_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign ready_o  = !valid_q || take_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule
